// ===== rtl/core/wav_pcm16_stream_parser_assert.svh =====
// Assertion helpers for the stream parser. Both sample on clk and stay quiet during reset.
`ifndef WAV_PCM16_STREAM_PARSER_ASSERT_SVH
`define WAV_PCM16_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication.
`define WPS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wav parser assertion failed");

// Next-cycle implication.
`define WPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wav parser assertion failed");

`endif

// ===== rtl/core/wps_pkg.sv =====
package wps_pkg;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_CHUNK  = 3'd1;
    localparam logic [2:0] PH_FMT    = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;
    localparam logic [2:0] PH_PAD    = 3'd5;
    localparam logic [2:0] PH_ERROR  = 3'd6;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_RIFF    = 3'd1;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
    localparam logic [2:0] ST_TRUNCATED   = 3'd3;
    localparam logic [2:0] ST_SIZE        = 3'd4;
    localparam logic [2:0] ST_NO_FMT      = 3'd5;
    localparam logic [2:0] ST_NO_DATA     = 3'd6;

    // Tags as they assemble little endian, first file byte in the low lane.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_CHUNK_LEN   = 32'd16;
    localparam logic [15:0] FMT_TAG_PCM     = 16'd1;
    localparam logic [15:0] BITS_PER_SAMPLE = 16'd16;
    localparam logic [31:0] HEADER_LEN      = 32'd12;

    localparam int OUT_DATA_W = 72;

    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] byte_count;
        logic [31:0] chunk_tag;
        logic [31:0] chunk_length;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] rate_value;
        logic        seen_fmt;
        logic        seen_data;
        logic [7:0]  low_sample_byte;
        logic        pad_pending;
    } parse_state_t;

    typedef struct packed {
        logic               valid;
        logic [1:0]         kind;
        logic signed [15:0] sample;
        logic [15:0]        channels;
        logic [31:0]        sample_rate;
        logic [2:0]         status;
    } parse_result_t;

    localparam parse_state_t STATE_INIT = '0;

endpackage

// ===== rtl/core/wps_step.sv =====
module wps_step
    import wps_pkg::*;
(
    input  parse_state_t  cur,
    input  logic [7:0]    byte_value,
    input  logic          end_marker,
    output parse_state_t  nxt,
    output parse_result_t res
);

    logic [31:0] pos;
    logic [31:0] pos_inc;
    logic [31:0] len_full;
    logic [15:0] bits_field;

    assign pos        = cur.byte_count;
    assign pos_inc    = pos + 32'd1;
    assign len_full   = {byte_value, cur.chunk_length[23:0]};
    assign bits_field = {byte_value, cur.low_sample_byte};

    always_comb
    begin
        nxt = cur;
        res = '0;
        if (end_marker)
        begin
            res.kind = KIND_STATUS;
            if (cur.phase == PH_HEADER)
            begin
                res.valid  = 1'b1;
                res.status = ST_BAD_RIFF;
            end
            else if (cur.phase == PH_FMT || cur.phase == PH_DATA)
            begin
                res.valid  = 1'b1;
                res.status = ST_TRUNCATED;
            end
            else if (cur.phase != PH_ERROR)
            begin
                res.valid = 1'b1;
                if (!cur.seen_fmt)
                    res.status = ST_NO_FMT;
                else if (!cur.seen_data)
                    res.status = ST_NO_DATA;
                else
                    res.status = ST_OK;
            end
            nxt = STATE_INIT;
        end
        else
        begin
            unique case (cur.phase)
                PH_HEADER:
                begin
                    if ((pos[3:2] == 2'd0 && byte_value != TAG_RIFF[pos[1:0]*8 +: 8]) ||
                        (pos[3:2] == 2'd2 && byte_value != TAG_WAVE[pos[1:0]*8 +: 8]))
                    begin
                        nxt.phase  = PH_ERROR;
                        res.valid  = 1'b1;
                        res.kind   = KIND_STATUS;
                        res.status = ST_BAD_RIFF;
                    end
                    else if (pos_inc >= HEADER_LEN)
                    begin
                        nxt.byte_count = '0;
                        nxt.phase      = PH_CHUNK;
                    end
                    else
                    begin
                        nxt.byte_count = pos_inc;
                    end
                end
                PH_CHUNK:
                begin
                    // Byte zero of each field clears the field it starts.
                    if (!pos[2])
                    begin
                        if (pos[1:0] == 2'd0)
                            nxt.chunk_tag = {24'h0, byte_value};
                        else
                            nxt.chunk_tag[pos[1:0]*8 +: 8] = byte_value;
                    end
                    else
                    begin
                        if (pos[1:0] == 2'd0)
                            nxt.chunk_length = {24'h0, byte_value};
                        else
                            nxt.chunk_length[pos[1:0]*8 +: 8] = byte_value;
                    end
                    nxt.byte_count = pos_inc;
                    if (pos[2:0] == 3'd7)
                    begin
                        nxt.byte_count  = '0;
                        nxt.pad_pending = len_full[0];
                        res.kind        = KIND_STATUS;
                        if (cur.chunk_tag == TAG_FMT)
                        begin
                            if (cur.seen_fmt)
                            begin
                                nxt.phase  = PH_ERROR;
                                res.valid  = 1'b1;
                                res.status = ST_BAD_RIFF;
                            end
                            else if (len_full != FMT_CHUNK_LEN)
                            begin
                                nxt.phase  = PH_ERROR;
                                res.valid  = 1'b1;
                                res.status = ST_UNSUPPORTED;
                            end
                            else
                            begin
                                nxt.phase = PH_FMT;
                            end
                        end
                        else if (cur.chunk_tag == TAG_DATA)
                        begin
                            if (cur.seen_data)
                            begin
                                nxt.phase  = PH_ERROR;
                                res.valid  = 1'b1;
                                res.status = ST_BAD_RIFF;
                            end
                            else if (len_full[0])
                            begin
                                nxt.phase  = PH_ERROR;
                                res.valid  = 1'b1;
                                res.status = ST_SIZE;
                            end
                            else if (len_full == 32'd0)
                            begin
                                nxt.seen_data = 1'b1;
                                nxt.phase     = PH_CHUNK;
                            end
                            else
                            begin
                                nxt.phase = PH_DATA;
                            end
                        end
                        else if (len_full == 32'd0)
                        begin
                            nxt.phase = PH_CHUNK;
                        end
                        else
                        begin
                            nxt.phase = PH_SKIP;
                        end
                    end
                end
                PH_FMT:
                begin
                    nxt.byte_count = pos_inc;
                    case (pos[3:0])
                        4'd0: nxt.format_tag = {8'h0, byte_value};
                        4'd1: nxt.format_tag[15:8] = byte_value;
                        4'd2: nxt.channel_count = {8'h0, byte_value};
                        4'd3: nxt.channel_count[15:8] = byte_value;
                        4'd4: nxt.rate_value = {24'h0, byte_value};
                        4'd5, 4'd6, 4'd7: nxt.rate_value[pos[1:0]*8 +: 8] = byte_value;
                        4'd14: nxt.low_sample_byte = byte_value;
                        4'd15:
                        begin
                            if (cur.format_tag != FMT_TAG_PCM || bits_field != BITS_PER_SAMPLE)
                            begin
                                nxt.phase  = PH_ERROR;
                                res.valid  = 1'b1;
                                res.kind   = KIND_STATUS;
                                res.status = ST_UNSUPPORTED;
                            end
                            else
                            begin
                                nxt.seen_fmt    = 1'b1;
                                nxt.byte_count  = '0;
                                nxt.phase       = PH_CHUNK;
                                res.valid       = 1'b1;
                                res.kind        = KIND_FORMAT;
                                res.channels    = cur.channel_count;
                                res.sample_rate = cur.rate_value;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_DATA:
                begin
                    nxt.byte_count = pos_inc;
                    if (!pos[0])
                    begin
                        nxt.low_sample_byte = byte_value;
                    end
                    else
                    begin
                        if (pos_inc == cur.chunk_length)
                        begin
                            nxt.seen_data  = 1'b1;
                            nxt.byte_count = '0;
                            nxt.phase      = PH_CHUNK;
                        end
                        res.valid  = 1'b1;
                        res.kind   = KIND_SAMPLE;
                        res.sample = {byte_value, cur.low_sample_byte};
                    end
                end
                PH_SKIP:
                begin
                    nxt.byte_count = pos_inc;
                    if (pos_inc == cur.chunk_length)
                    begin
                        nxt.byte_count = '0;
                        nxt.phase      = cur.pad_pending ? PH_PAD : PH_CHUNK;
                    end
                end
                PH_PAD:
                begin
                    nxt.pad_pending = 1'b0;
                    nxt.byte_count  = '0;
                    nxt.phase       = PH_CHUNK;
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/wav_pcm16_stream_parser.sv =====
// Channel  Direction  Contents
// s_*      in         tdata[7:0] file byte, tlast = end of file (byte ignored)
// m_*      out        tuser = kind, tdata = sample, channels, rate, status
//
// One byte per cycle while s_tready is high: each accepted request updates the
// parser state register, and its result (if any) lands in the output register at the same edge.
// s_tready stays high while the output register is empty or being taken, so
// only a stalled pending result holds input back.
// Reset puts the parser at the start of the RIFF header with no result pending.
module wav_pcm16_stream_parser
    import wps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,  // [7:0] byte_value
    input  logic                  s_tlast,  // end_marker
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // [15:0] sample, [31:16] channels,
                                            // [63:32] sample_rate, [66:64] status
    output logic [1:0]            m_tuser   // [1:0] kind
);

    `include "wav_pcm16_stream_parser_assert.svh"

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t step_res;
    parse_result_t out_reg;
    logic          out_valid_reg;
    logic          accept;

    wps_step u_step (
        .cur        (state_reg),
        .byte_value (s_tdata),
        .end_marker (s_tlast),
        .nxt        (state_next),
        .res        (step_res)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (accept && step_res.valid)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && step_res.valid)
            out_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {5'h0, out_reg.status, out_reg.sample_rate,
                       out_reg.channels, out_reg.sample};

    `WPS_ASSERT_NEXT(a_end_restarts, accept && s_tlast,
        state_reg.phase == PH_HEADER && state_reg.byte_count == 32'd0 && !state_reg.seen_fmt)
    `WPS_ASSERT_IMPLY(a_error_silent, accept && !s_tlast && state_reg.phase == PH_ERROR,
        !step_res.valid)
    `WPS_ASSERT_IMPLY(a_header_bound, state_reg.phase == PH_HEADER,
        state_reg.byte_count < HEADER_LEN)
    `WPS_ASSERT_IMPLY(a_sample_clean, m_tvalid && m_tuser == KIND_SAMPLE,
        m_tdata[66:16] == 51'd0)

endmodule

// ===== bench/tb_wav_pcm16_stream_parser.sv =====
module tb_wav_pcm16_stream_parser
    import wps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT     = 400000;
    localparam int RANDOM_ITEMS  = 860;
    localparam int HOLD_AT_COUNT = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;

    // One row of the directed table: the byte, the end flag and the typed-in result.
    typedef struct packed {
        logic       has_result;
        logic [2:0] status;
        logic       eof;
        logic [7:0] value;
    } dir_row_t;

    typedef struct packed {
        logic          hold_first;
        logic          typed;
        parse_result_t typed_result;
        logic          eof;
        logic [7:0]    value;
    } byte_req_t;

    localparam int DIR_ROWS = 20;
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{1'b1, ST_BAD_RIFF, 1'b1, 8'h00},  // end of file before any header byte
        '{1'b1, ST_BAD_RIFF, 1'b0, 8'h00},  // wrong first tag byte
        '{1'b0, ST_OK,       1'b0, 8'hFF},  // ignored after the error
        '{1'b0, ST_OK,       1'b1, 8'hFF},  // end after an error is silent
        '{1'b0, ST_OK,       1'b0, 8'h52},  // R
        '{1'b0, ST_OK,       1'b0, 8'h49},  // I
        '{1'b0, ST_OK,       1'b0, 8'h46},  // F
        '{1'b0, ST_OK,       1'b0, 8'h46},  // F
        '{1'b0, ST_OK,       1'b0, 8'hFF},  // RIFF size bytes are never checked
        '{1'b0, ST_OK,       1'b0, 8'h00},
        '{1'b0, ST_OK,       1'b0, 8'h80},
        '{1'b0, ST_OK,       1'b0, 8'h7F},
        '{1'b0, ST_OK,       1'b0, 8'h57},  // W
        '{1'b0, ST_OK,       1'b0, 8'h41},  // A
        '{1'b0, ST_OK,       1'b0, 8'h56},  // V
        '{1'b1, ST_BAD_RIFF, 1'b0, 8'h58},  // X in place of E
        '{1'b0, ST_OK,       1'b1, 8'h00},
        '{1'b0, ST_OK,       1'b0, 8'h52},
        '{1'b0, ST_OK,       1'b0, 8'h49},
        '{1'b1, ST_BAD_RIFF, 1'b1, 8'h00}   // end inside the RIFF header
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] byte_value
    logic                  s_tlast;   // end_marker
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // [15:0] sample, [31:16] channels,
                                      // [63:32] sample_rate, [66:64] status
    logic [1:0]            m_tuser;   // [1:0] kind

    parse_state_t  parser;
    parse_result_t pending_results[$];
    byte_req_t     byte_plan[$];
    logic [7:0]    file_bytes[$];
    int            error_count;
    int            cycle_count;

    wav_pcm16_stream_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("tb_wav_pcm16_stream_parser NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < 40)
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
        error_count++;
    endtask

    // A status result also stops the walk; end of file overwrites the phase afterwards.
    function automatic parse_result_t status_report(input logic [2:0] st);
        parse_result_t r;
        r = '0;
        r.valid  = 1'b1;
        r.kind   = KIND_STATUS;
        r.status = st;
        parser.phase = PH_ERROR;
        return r;
    endfunction

    task automatic wave_predict(input logic [7:0] b, input logic eof,
                                output parse_result_t r);
        logic [31:0] pos;
        logic [15:0] bits;
        r   = '0;
        pos = parser.byte_count;
        if (eof)
        begin
            if (parser.phase == PH_HEADER)
                r = status_report(ST_BAD_RIFF);
            else if (parser.phase == PH_FMT || parser.phase == PH_DATA)
                r = status_report(ST_TRUNCATED);
            else if (parser.phase != PH_ERROR)
            begin
                if (!parser.seen_fmt)
                    r = status_report(ST_NO_FMT);
                else if (!parser.seen_data)
                    r = status_report(ST_NO_DATA);
                else
                    r = status_report(ST_OK);
            end
            parser = STATE_INIT;
        end
        else
        begin
            case (parser.phase)
                PH_HEADER:
                begin
                    if ((pos < 4 && b != TAG_RIFF[{pos[1:0], 3'b000} +: 8]) ||
                        (pos >= 8 && pos < 12 && b != TAG_WAVE[{pos[1:0], 3'b000} +: 8]))
                        r = status_report(ST_BAD_RIFF);
                    else
                    begin
                        parser.byte_count = pos + 1;
                        if (parser.byte_count >= HEADER_LEN)
                        begin
                            parser.byte_count = 0;
                            parser.phase      = PH_CHUNK;
                        end
                    end
                end
                PH_CHUNK:
                begin
                    if (pos < 4)
                    begin
                        if (pos == 0)
                            parser.chunk_tag = '0;
                        parser.chunk_tag[{pos[1:0], 3'b000} +: 8] = b;
                    end
                    else
                    begin
                        if (pos == 4)
                            parser.chunk_length = '0;
                        parser.chunk_length[{pos[1:0], 3'b000} +: 8] = b;
                    end
                    parser.byte_count = pos + 1;
                    if (parser.byte_count == 8)
                    begin
                        parser.byte_count  = 0;
                        parser.pad_pending = parser.chunk_length[0];
                        if (parser.chunk_tag == TAG_FMT)
                        begin
                            if (parser.seen_fmt)
                                r = status_report(ST_BAD_RIFF);
                            else if (parser.chunk_length != FMT_CHUNK_LEN)
                                r = status_report(ST_UNSUPPORTED);
                            else
                                parser.phase = PH_FMT;
                        end
                        else if (parser.chunk_tag == TAG_DATA)
                        begin
                            if (parser.seen_data)
                                r = status_report(ST_BAD_RIFF);
                            else if (parser.pad_pending)
                                r = status_report(ST_SIZE);
                            else if (parser.chunk_length == 0)
                                parser.seen_data = 1'b1;
                            else
                                parser.phase = PH_DATA;
                        end
                        else if (parser.chunk_length != 0)
                            parser.phase = PH_SKIP;
                    end
                end
                PH_FMT:
                begin
                    parser.byte_count = pos + 1;
                    case (pos)
                        0: parser.format_tag = {8'h00, b};
                        1: parser.format_tag[15:8] = b;
                        2: parser.channel_count = {8'h00, b};
                        3: parser.channel_count[15:8] = b;
                        4, 5, 6, 7:
                        begin
                            if (pos == 4)
                                parser.rate_value = '0;
                            parser.rate_value[{pos[1:0], 3'b000} +: 8] = b;
                        end
                        14: parser.low_sample_byte = b;
                        15:
                        begin
                            bits = {b, parser.low_sample_byte};
                            if (parser.format_tag != FMT_TAG_PCM || bits != BITS_PER_SAMPLE)
                                r = status_report(ST_UNSUPPORTED);
                            else
                            begin
                                parser.seen_fmt   = 1'b1;
                                parser.byte_count = 0;
                                parser.phase      = PH_CHUNK;
                                r.valid       = 1'b1;
                                r.kind        = KIND_FORMAT;
                                r.channels    = parser.channel_count;
                                r.sample_rate = parser.rate_value;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_DATA:
                begin
                    parser.byte_count = pos + 1;
                    if (!pos[0])
                        parser.low_sample_byte = b;
                    else
                    begin
                        if (parser.byte_count == parser.chunk_length)
                        begin
                            parser.seen_data  = 1'b1;
                            parser.byte_count = 0;
                            parser.phase      = PH_CHUNK;
                        end
                        r.valid  = 1'b1;
                        r.kind   = KIND_SAMPLE;
                        r.sample = {b, parser.low_sample_byte};
                    end
                end
                PH_SKIP:
                begin
                    parser.byte_count = pos + 1;
                    if (parser.byte_count == parser.chunk_length)
                    begin
                        parser.byte_count = 0;
                        parser.phase      = parser.pad_pending ? PH_PAD : PH_CHUNK;
                    end
                end
                PH_PAD:
                begin
                    parser.pad_pending = 1'b0;
                    parser.byte_count  = 0;
                    parser.phase       = PH_CHUNK;
                end
                default: ;
            endcase
        end
    endtask

    task automatic plan_byte(input logic [7:0] value, input logic eof, input logic hold_first);
        byte_req_t req;
        req = '0;
        req.value      = value;
        req.eof        = eof;
        req.hold_first = hold_first;
        byte_plan.push_back(req);
    endtask

    task automatic push_half(input logic [15:0] h);
        file_bytes.push_back(h[7:0]);
        file_bytes.push_back(h[15:8]);
    endtask

    task automatic push_word(input logic [31:0] w);
        push_half(w[15:0]);
        push_half(w[31:16]);
    endtask

    task automatic push_random(input int count);
        repeat (count) file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // One file: mostly a proper RIFF/WAVE walk with random content, sometimes
    // noise, a broken tag, an unsupported format, a bad size or a cut-off tail.
    task automatic plan_wave_file(input logic hold_first);
        int          chunk_total;
        int          len;
        int          cut;
        int          pick;
        int          idx;
        logic        fmt_used;
        logic        data_used;
        logic [15:0] word16;
        fmt_used  = 1'b0;
        data_used = 1'b0;
        file_bytes.delete();
        if ($urandom_range(0, 9) == 0)
            push_random($urandom_range(0, 24));
        else
        begin
            push_word(TAG_RIFF);
            push_word($urandom);
            push_word(TAG_WAVE);
            if ($urandom_range(0, 9) == 0)
            begin
                idx = $urandom_range(0, 11);
                file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
            end
            chunk_total = $urandom_range(1, 5);
            repeat (chunk_total)
            begin
                pick = $urandom_range(0, 3);
                if (pick != 0 && (!fmt_used || $urandom_range(0, 11) == 0))
                begin
                    fmt_used = 1'b1;
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : 16;
                    push_word(TAG_FMT);
                    push_word(len);
                    if (len == 16)
                    begin
                        push_half(($urandom_range(0, 9) == 0) ? 16'($urandom) : FMT_TAG_PCM);
                        push_half(16'($urandom));
                        push_word($urandom);
                        push_word($urandom);
                        push_half(16'($urandom));
                        push_half(($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                              : BITS_PER_SAMPLE);
                    end
                    else
                        push_random($urandom_range(0, 3));
                end
                else if (pick != 0 && (!data_used || $urandom_range(0, 7) == 0))
                begin
                    data_used = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        len = 2 * $urandom_range(0, 8) + 1;
                    else
                        len = 2 * $urandom_range(0, 10);
                    push_word(TAG_DATA);
                    push_word(len);
                    for (int k = 0; k + 1 < len; k += 2)
                    begin
                        case ($urandom_range(0, 7))
                            0: word16 = 16'h8000;
                            1: word16 = 16'h7FFF;
                            2: word16 = 16'hFFFF;
                            3: word16 = 16'h0000;
                            default: word16 = 16'($urandom);
                        endcase
                        push_half(word16);
                    end
                end
                else
                begin
                    len = $urandom_range(0, 7);
                    push_word($urandom);
                    push_word(len);
                    push_random(len + (len % 2));
                end
            end
            if ($urandom_range(0, 4) == 0)
            begin
                cut = $urandom_range(0, file_bytes.size());
                while (file_bytes.size() > cut)
                    void'(file_bytes.pop_back());
            end
        end
        foreach (file_bytes[i])
            plan_byte(file_bytes[i], 1'b0, hold_first && i == 0);
        plan_byte(8'($urandom_range(0, 255)), 1'b1, hold_first && file_bytes.size() == 0);
    endtask

    initial
    begin : result_sink
        int            wait_cycles;
        int            taken;
        logic          quiet;
        parse_result_t want;
        taken = 0;
        quiet = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                quiet = !quiet;
            wait_cycles = quiet ? 0 : $urandom_range(0, 15);
            if (taken == HOLD_AT_COUNT)
                wait_cycles = HOLD_CYCLES;
            if (wait_cycles != 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            taken++;
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected", {30'h0, m_tuser}, '0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", {30'h0, m_tuser}, {30'h0, want.kind});
                if (m_tdata[15:0] !== want.sample)
                    report_mismatch("sample", {16'h0, m_tdata[15:0]}, {16'h0, want.sample});
                if (m_tdata[31:16] !== want.channels)
                    report_mismatch("channels", {16'h0, m_tdata[31:16]},
                                    {16'h0, want.channels});
                if (m_tdata[63:32] !== want.sample_rate)
                    report_mismatch("sample_rate", m_tdata[63:32], want.sample_rate);
                if (m_tdata[66:64] !== want.status)
                    report_mismatch("status", {29'h0, m_tdata[66:64]}, {29'h0, want.status});
            end
        end
    end

    initial
    begin : byte_source
        int            gap;
        int            file_index;
        logic          quiet;
        byte_req_t     req;
        parse_result_t predicted;
        error_count = 0;
        file_index  = 0;
        quiet       = 1'b0;
        parser      = STATE_INIT;
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            plan_byte(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].eof, 1'b0);
            byte_plan[byte_plan.size() - 1].typed = 1'b1;
            if (DIRECTED_ROWS[r].has_result)
                byte_plan[byte_plan.size() - 1].typed_result =
                    '{1'b1, KIND_STATUS, 16'sd0, 16'd0, 32'd0, DIRECTED_ROWS[r].status};
        end
        // Every fourth file waits for the output side to drain completely first.
        while (byte_plan.size() < DIR_ROWS + RANDOM_ITEMS)
        begin
            plan_wave_file(file_index % 4 == 0);
            file_index++;
        end

        wait (rst_n === 1'b1);
        @(posedge clk);
        for (int i = 0; i < byte_plan.size(); i++)
        begin
            req = byte_plan[i];
            if ($urandom_range(0, 39) == 0)
                quiet = !quiet;
            gap = quiet ? 0 : $urandom_range(0, 15);
            if (req.hold_first && gap == 0)
                gap = 1;
            if (gap != 0)
                s_tvalid <= 1'b0;
            if (req.hold_first)
                while (pending_results.size() != 0)
                    @(posedge clk);
            repeat (gap) @(posedge clk);
            s_tdata  <= req.value;
            s_tlast  <= req.eof;
            s_tvalid <= 1'b1;
            do
                @(posedge clk);
            while (s_tready !== 1'b1);
            wave_predict(req.value, req.eof, predicted);
            if (req.typed)
                predicted = req.typed_result;
            if (predicted.valid)
                pending_results.push_back(predicted);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_wav_pcm16_stream_parser OK");
        else
            $display("tb_wav_pcm16_stream_parser NOT OK");
        $finish;
    end

endmodule

// ===== wav_pcm16_stream_parser.f =====
+incdir+rtl/core
rtl/core/wps_pkg.sv
rtl/core/wps_step.sv
rtl/core/wav_pcm16_stream_parser.sv
bench/tb_wav_pcm16_stream_parser.sv
